// File: rtl/rmd_pkg.sv
// Shared types, widths and helper functions for the region merge distance block.
package rmd_pkg;

    localparam int COLOR_W        = 16;
    localparam int COUNT_W        = 21;
    localparam int DIST_W         = 38;
    localparam int COLOR_FRAC_BITS = 8;

    localparam logic [COUNT_W-1:0] MAX_REGION_PIXELS = COUNT_W'(1048576);

    // Sum of three absolute channel differences.
    localparam int L1_W    = COLOR_W + 2;
    // One squared channel difference and the sum of three of them.
    localparam int SQ_W    = 2 * COLOR_W;
    localparam int SUMSQ_W = SQ_W + 2;

    // Root bits resolved in each pipeline stage of the square root.
    localparam int SQ_BITS_PER_STAGE = 2;
    localparam int SQRT_STAGES       = (SUMSQ_W + 2 * SQ_BITS_PER_STAGE - 1)
                                       / (2 * SQ_BITS_PER_STAGE);

    // The radicand is padded with leading zeros so that every stage consumes
    // its full share of radicand bits.
    localparam int SQ_IN_W = 2 * SQ_BITS_PER_STAGE * SQRT_STAGES;
    localparam int ROOT_W  = SQ_IN_W / 2;
    localparam int REM_W   = ROOT_W + 2;

    localparam int PROD_W = COUNT_W + ROOT_W;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic {
        MODE_L1       = 1'b0,
        MODE_WEIGHTED = 1'b1
    } t_mode;

    typedef struct packed {
        logic [COLOR_W-1:0] a_red;
        logic [COLOR_W-1:0] a_green;
        logic [COLOR_W-1:0] a_blue;
        logic [COUNT_W-1:0] count_a;
        logic [COLOR_W-1:0] b_red;
        logic [COLOR_W-1:0] b_green;
        logic [COLOR_W-1:0] b_blue;
        logic [COUNT_W-1:0] count_b;
    } t_in_item;

    // Values that ride alongside the square root untouched.
    typedef struct packed {
        t_mode              mode;
        logic [COUNT_W-1:0] cmin;
        logic [L1_W-1:0]    l1;
    } t_side;

    typedef struct packed {
        t_side              side;
        logic [SUMSQ_W-1:0] sumsq;
    } t_front_data;

    typedef struct packed {
        logic [SQ_IN_W-1:0] val;
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
    } t_sq_state;

    typedef struct packed {
        t_side             side;
        logic [ROOT_W-1:0] root;
    } t_root_data;

    function automatic logic [COLOR_W-1:0] abs_diff(logic [COLOR_W-1:0] x,
                                                    logic [COLOR_W-1:0] y);
        return (x > y) ? (x - y) : (y - x);
    endfunction

    function automatic logic [COUNT_W-1:0] clamp_count(logic [COUNT_W-1:0] c);
        return (c > MAX_REGION_PIXELS) ? MAX_REGION_PIXELS : c;
    endfunction

    // Digit recurrence for the floor square root, a few root bits per call.
    function automatic t_sq_state sqrt_step(t_sq_state s);
        t_sq_state        r;
        logic [REM_W-1:0] trial;
        r = s;
        for (int i = 0; i < SQ_BITS_PER_STAGE; i++) begin
            r.rem = {r.rem[REM_W-3:0], r.val[SQ_IN_W-1 -: 2]};
            r.val = {r.val[SQ_IN_W-3:0], 2'b00};
            trial = {r.root, 2'b01};
            if (r.rem >= trial) begin
                r.rem  = r.rem - trial;
                r.root = {r.root[ROOT_W-2:0], 1'b1};
            end else begin
                r.root = {r.root[ROOT_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/rmd_front.sv
// Front pipeline: channel differences, count clamp, absolute sum, squares and sum of squares.
module rmd_front import rmd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_item,
    input  t_mode       i_mode,
    output logic        o_valid,
    input  logic        i_ready,
    output t_front_data o_data
);

    logic [2:0] r_v;
    logic [2:0] w_rdy;

    // Stage 1 registers.
    t_mode              r1_mode;
    logic [COUNT_W-1:0] r1_cmin;
    logic [COLOR_W-1:0] r1_dr, r1_dg, r1_db;

    // Stage 2 registers.
    t_mode              r2_mode;
    logic [COUNT_W-1:0] r2_cmin;
    logic [L1_W-1:0]    r2_l1;
    logic [SQ_W-1:0]    r2_sr, r2_sg, r2_sb;

    // Stage 3 registers.
    t_front_data        r3_data;

    logic [COUNT_W-1:0] n_ca, n_cb;

    assign n_ca = clamp_count(i_item.count_a);
    assign n_cb = clamp_count(i_item.count_b);

    // A stage takes new data when it is empty or its content moves on.
    assign w_rdy[2] = !r_v[2] || i_ready;
    assign w_rdy[1] = !r_v[1] || w_rdy[2];
    assign w_rdy[0] = !r_v[0] || w_rdy[1];
    assign o_ready  = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            if (w_rdy[1]) r_v[1] <= r_v[0];
            if (w_rdy[2]) r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r1_mode <= i_mode;
            r1_cmin <= (n_ca < n_cb) ? n_ca : n_cb;
            r1_dr   <= abs_diff(i_item.a_red,   i_item.b_red);
            r1_dg   <= abs_diff(i_item.a_green, i_item.b_green);
            r1_db   <= abs_diff(i_item.a_blue,  i_item.b_blue);
        end
        if (w_rdy[1]) begin
            r2_mode <= r1_mode;
            r2_cmin <= r1_cmin;
            r2_l1   <= L1_W'(r1_dr) + L1_W'(r1_dg) + L1_W'(r1_db);
            r2_sr   <= SQ_W'(r1_dr) * SQ_W'(r1_dr);
            r2_sg   <= SQ_W'(r1_dg) * SQ_W'(r1_dg);
            r2_sb   <= SQ_W'(r1_db) * SQ_W'(r1_db);
        end
        if (w_rdy[2]) begin
            r3_data.side.mode <= r2_mode;
            r3_data.side.cmin <= r2_cmin;
            r3_data.side.l1   <= r2_l1;
            r3_data.sumsq     <= SUMSQ_W'(r2_sr) + SUMSQ_W'(r2_sg) + SUMSQ_W'(r2_sb);
        end
    end

    assign o_valid = r_v[2];
    assign o_data  = r3_data;

endmodule

// File: rtl/rmd_sqrt.sv
// Pipelined floor square root that resolves a few root bits per stage.
module rmd_sqrt import rmd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_front_data i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_root_data  o_data
);

    logic      [SQRT_STAGES-1:0] r_v;
    logic      [SQRT_STAGES:0]   w_rdy;
    t_sq_state r_st   [SQRT_STAGES];
    t_side     r_side [SQRT_STAGES];
    t_sq_state w_st_in   [SQRT_STAGES];
    t_side     w_side_in [SQRT_STAGES];
    logic      [SQRT_STAGES-1:0] w_v_in;

    assign w_rdy[SQRT_STAGES] = i_ready;

    genvar k;
    generate
        for (k = 0; k < SQRT_STAGES; k++) begin : g_stage
            if (k == 0) begin : g_first
                assign w_st_in[k]   = {SQ_IN_W'(i_data.sumsq), {REM_W{1'b0}},
                                       {ROOT_W{1'b0}}};
                assign w_side_in[k] = i_data.side;
                assign w_v_in[k]    = i_valid;
            end else begin : g_next
                assign w_st_in[k]   = r_st[k-1];
                assign w_side_in[k] = r_side[k-1];
                assign w_v_in[k]    = r_v[k-1];
            end

            assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < SQRT_STAGES; s++) begin
                if (w_rdy[s]) begin
                    r_v[s] <= w_v_in[s];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < SQRT_STAGES; s++) begin
            if (w_rdy[s]) begin
                r_st[s]   <= sqrt_step(w_st_in[s]);
                r_side[s] <= w_side_in[s];
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[SQRT_STAGES-1];
    assign o_data  = {r_side[SQRT_STAGES-1], r_st[SQRT_STAGES-1].root};

endmodule

// File: rtl/rmd_out.sv
// Output stage: count times root or the plain sum, saturated, in the output register.
module rmd_out import rmd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_root_data        i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [DIST_W-1:0] o_distance
);

    logic              r_v;
    logic [DIST_W-1:0] r_dist;
    logic [PROD_W-1:0] w_prod;
    logic [DIST_W-1:0] n_dist;
    logic              w_rdy;

    assign w_prod = PROD_W'(i_data.side.cmin) * PROD_W'(i_data.root);

    always_comb begin
        unique case (i_data.side.mode)
            MODE_L1:       n_dist = DIST_W'(i_data.side.l1);
            MODE_WEIGHTED: n_dist = (|w_prod[PROD_W-1:DIST_W]) ? DIST_MAX
                                                                : w_prod[DIST_W-1:0];
            default:       n_dist = '0;
        endcase
    end

    assign w_rdy = !r_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy) begin
            r_dist <= n_dist;
        end
    end

    assign o_ready    = w_rdy;
    assign o_valid    = r_v;
    assign o_distance = r_dist;

endmodule

// File: rtl/region_merge_distance.sv
// Top level of the region merge distance block: merging cost of two adjacent regions.
//
//   Channel   Direction  Handshake           Payload
//   input     in         i_valid / o_stall   i_a_*, i_count_a, i_b_*, i_count_b
//   output    out        o_valid / i_stall   o_distance
//   config    in         i_cfg_we            i_cfg_data (merge mode)
//
// One transaction enters per cycle while o_stall is low, and passes through
// three front stages (differences, squares, sum of squares), nine square root
// stages of two root bits each, and the output register with the multiplier.
// Every stage holds its own valid bit and loads whenever it is empty or its
// content moves on, so bubbles close up and a stalled output holds its result
// while upstream stages keep filling. o_stall rises only when every stage is full.
// Reset is synchronous and active low; it empties the pipeline and sets the
// merge mode to the size weighted cost.
module region_merge_distance import rmd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [COLOR_W-1:0] i_a_red,
    input  logic [COLOR_W-1:0] i_a_green,
    input  logic [COLOR_W-1:0] i_a_blue,
    input  logic [COUNT_W-1:0] i_count_a,
    input  logic [COLOR_W-1:0] i_b_red,
    input  logic [COLOR_W-1:0] i_b_green,
    input  logic [COLOR_W-1:0] i_b_blue,
    input  logic [COUNT_W-1:0] i_count_b,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [DIST_W-1:0]  o_distance
);

    // Merge mode register; the user must write it only while the pipeline is empty;
    // the block itself does not enforce this. Each transaction samples it on entry.
    t_mode       r_mode;
    t_in_item    w_item;
    t_front_data w_front;
    t_root_data  w_root;
    logic        w_in_ready;
    logic        w_front_valid, w_front_ready;
    logic        w_root_valid,  w_root_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_WEIGHTED;
        end else if (i_cfg_we) begin
            r_mode <= t_mode'(i_cfg_data);
        end
    end

    assign w_item.a_red   = i_a_red;
    assign w_item.a_green = i_a_green;
    assign w_item.a_blue  = i_a_blue;
    assign w_item.count_a = i_count_a;
    assign w_item.b_red   = i_b_red;
    assign w_item.b_green = i_b_green;
    assign w_item.b_blue  = i_b_blue;
    assign w_item.count_b = i_count_b;

    rmd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (w_in_ready),
        .i_item  (w_item),
        .i_mode  (r_mode),
        .o_valid (w_front_valid),
        .i_ready (w_front_ready),
        .o_data  (w_front)
    );

    rmd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_valid),
        .o_ready (w_front_ready),
        .i_data  (w_front),
        .o_valid (w_root_valid),
        .i_ready (w_root_ready),
        .o_data  (w_root)
    );

    rmd_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_root_valid),
        .o_ready    (w_root_ready),
        .i_data     (w_root),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_distance (o_distance)
    );

    assign o_stall = !w_in_ready;

`ifndef SYNTHESIS
    // Back pressure reaches the input only when the result register is blocked.
    a_stall_needs_blocked_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while the output is not blocked");

    // The radicand is below 2^34, so the top root bit is never set.
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_valid |-> !w_root.root[ROOT_W-1])
        else $error("square root out of range");

    // The smaller count has already been clamped to the region limit.
    a_cmin_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_front_valid |-> (w_front.side.cmin <= MAX_REGION_PIXELS))
        else $error("pixel count not clamped");
`endif

endmodule

// File: tb/sv/region_merge_distance_test.sv
// Self-checking testbench for the region merge distance block.
`timescale 1ns / 1ps

module region_merge_distance_test;
    import rmd_pkg::*;

    // Generous bound on the whole run.
    localparam int CYCLE_LIMIT   = 400000;
    // Idle waits outlast the pipeline from input to result.
    localparam int PIPE_SETTLE   = 20;
    localparam int PHASE_ITEMS   = 190;

    // Keeps the expected costs of accepted transactions in arrival order and checks results.
    class merge_cost_board;
        t_mode             mode;
        logic [DIST_W-1:0] cost_queue[$];
        int unsigned       mismatches;
        int unsigned       checked;

        function new();
            mode       = MODE_WEIGHTED;
            mismatches = 0;
            checked    = 0;
        endfunction

        // Floor square root, built one root bit at a time from the top.
        function automatic logic [17:0] floor_root(logic [33:0] radicand);
            logic [17:0] root;
            logic [17:0] trial;
            root = '0;
            for (int b = 17; b >= 0; b--) begin
                trial = root | (18'd1 << b);
                if (36'(trial) * 36'(trial) <= 36'(radicand)) begin
                    root = trial;
                end
            end
            return root;
        endfunction

        function automatic logic [COLOR_W-1:0] chan_gap(logic [COLOR_W-1:0] x,
                                                        logic [COLOR_W-1:0] y);
            return (x > y) ? (x - y) : (y - x);
        endfunction

        // Merging cost of one region pair under the current mode.
        function automatic logic [DIST_W-1:0] merge_cost(t_in_item it);
            logic [COLOR_W-1:0]    dr, dg, db;
            logic [COUNT_W-1:0]    ca, cb, cmin;
            logic [33:0]           sumsq;
            logic [COUNT_W+17:0]   prod;
            dr = chan_gap(it.a_red, it.b_red);
            dg = chan_gap(it.a_green, it.b_green);
            db = chan_gap(it.a_blue, it.b_blue);
            if (mode == MODE_L1) begin
                return DIST_W'(dr) + DIST_W'(dg) + DIST_W'(db);
            end
            // Counts above the region limit are clamped before the smaller one is taken.
            ca    = (it.count_a > MAX_REGION_PIXELS) ? MAX_REGION_PIXELS : it.count_a;
            cb    = (it.count_b > MAX_REGION_PIXELS) ? MAX_REGION_PIXELS : it.count_b;
            cmin  = (ca < cb) ? ca : cb;
            sumsq = 34'(dr) * 34'(dr) + 34'(dg) * 34'(dg) + 34'(db) * 34'(db);
            prod  = (COUNT_W+18)'(cmin) * (COUNT_W+18)'(floor_root(sumsq));
            if (prod > (COUNT_W+18)'(DIST_MAX)) begin
                return DIST_MAX;
            end
            return prod[DIST_W-1:0];
        endfunction

        function void note_input(t_in_item it);
            cost_queue.push_back(merge_cost(it));
        endfunction

        function void check_result(logic [DIST_W-1:0] got);
            logic [DIST_W-1:0] want;
            checked++;
            if (cost_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected result, distance %0d", $realtime, got);
                end
                return;
            end
            want = cost_queue.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: distance mismatch, expected %0d, got %0d",
                             $realtime, want, got);
                end
            end
        endfunction

        function int outstanding();
            return cost_queue.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic [COLOR_W-1:0] i_a_red;
    logic [COLOR_W-1:0] i_a_green;
    logic [COLOR_W-1:0] i_a_blue;
    logic [COUNT_W-1:0] i_count_a;
    logic [COLOR_W-1:0] i_b_red;
    logic [COLOR_W-1:0] i_b_green;
    logic [COLOR_W-1:0] i_b_blue;
    logic [COUNT_W-1:0] i_count_b;
    logic               o_valid;
    logic               i_stall;
    logic [DIST_W-1:0]  o_distance;

    merge_cost_board board;
    int unsigned     idle_pct;
    int unsigned     stall_pct;
    int unsigned     cycles;
    int unsigned     sent_count;
    int unsigned     mode_writes;

    region_merge_distance uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_a_red    (i_a_red),
        .i_a_green  (i_a_green),
        .i_a_blue   (i_a_blue),
        .i_count_a  (i_count_a),
        .i_b_red    (i_b_red),
        .i_b_green  (i_b_green),
        .i_b_blue   (i_b_blue),
        .i_count_b  (i_count_b),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_distance (o_distance)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // The run ends on a timeout if the pipeline hangs or loses a transaction.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results still expected",
                     cycles, board.outstanding());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver side: stall at random with the probability of the current phase.
    always @(posedge i_clk) begin
        i_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Every result transaction is checked against the oldest expected cost.
    // Outputs are read at the edge, before the block's own updates take effect.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_result(o_distance);
        end
    end

    function automatic t_in_item pair_of(logic [COLOR_W-1:0] ar, logic [COLOR_W-1:0] ag,
                                         logic [COLOR_W-1:0] ab, logic [COUNT_W-1:0] ca,
                                         logic [COLOR_W-1:0] br, logic [COLOR_W-1:0] bg,
                                         logic [COLOR_W-1:0] bb, logic [COUNT_W-1:0] cb);
        t_in_item it;
        it.a_red   = ar;
        it.a_green = ag;
        it.a_blue  = ab;
        it.count_a = ca;
        it.b_red   = br;
        it.b_green = bg;
        it.b_blue  = bb;
        it.count_b = cb;
        return it;
    endfunction

    // Colors lean toward the extremes and small values, where corner cases sit.
    function automatic logic [COLOR_W-1:0] pick_color();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return COLOR_W'($urandom_range(255));
            default: return COLOR_W'($urandom);
        endcase
    endfunction

    // Counts cover empty regions, the clamp boundary and values above the limit.
    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(9))
            0: return '0;
            1: return COUNT_W'(1);
            2: return MAX_REGION_PIXELS;
            3: return MAX_REGION_PIXELS + COUNT_W'(1);
            4: return '1;
            5: return COUNT_W'($urandom_range(1000));
            6: return COUNT_W'($urandom_range(2097151, 1048577));
            default: return COUNT_W'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_pair();
        t_in_item it;
        it = pair_of(pick_color(), pick_color(), pick_color(), pick_count(),
                     pick_color(), pick_color(), pick_color(), pick_count());
        // Adjacent regions often have close colors; small gaps stress the square root.
        if ($urandom_range(3) == 0) begin
            it.b_red   = it.a_red + COLOR_W'($urandom_range(8)) - COLOR_W'(4);
            it.b_green = it.a_green + COLOR_W'($urandom_range(8)) - COLOR_W'(4);
            it.b_blue  = it.a_blue + COLOR_W'($urandom_range(8)) - COLOR_W'(4);
        end
        if ($urandom_range(7) == 0) begin
            it.count_b = it.count_a;
        end
        return it;
    endfunction

    // Sends one transaction, with random idle cycles before it, and waits until it is taken.
    task automatic send_pair(input t_in_item it);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_a_red   <= it.a_red;
        i_a_green <= it.a_green;
        i_a_blue  <= it.a_blue;
        i_count_a <= it.count_a;
        i_b_red   <= it.b_red;
        i_b_green <= it.b_green;
        i_b_blue  <= it.b_blue;
        i_count_b <= it.count_b;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        board.note_input(it);
        sent_count++;
    endtask

    // Holds the sender back until every expected result has come out.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (board.outstanding() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // The mode register is only written while the pipeline is empty.
    task automatic set_merge_mode(input t_mode m);
        drain_results();
        repeat (PIPE_SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        board.mode = m;
        mode_writes++;
    endtask

    task automatic run_phase(input t_mode m, input int unsigned idle, input int unsigned stall);
        set_merge_mode(m);
        idle_pct  = idle;
        stall_pct = stall;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Midway through each phase the sender waits for the pipeline to empty.
            if (n == PHASE_ITEMS / 2) begin
                drain_results();
            end
            send_pair(random_pair());
        end
    endtask

    initial begin
        board       = new();
        cycles      = 0;
        sent_count  = 0;
        mode_writes = 0;
        idle_pct    = 0;
        stall_pct   = 0;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= 1'b0;
        i_valid    <= 1'b0;
        i_stall    <= 1'b0;
        i_a_red    <= '0;
        i_a_green  <= '0;
        i_a_blue   <= '0;
        i_count_a  <= '0;
        i_b_red    <= '0;
        i_b_green  <= '0;
        i_b_blue   <= '0;
        i_count_b  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pairs in the size weighted mode that reset selects.
        send_pair(pair_of('0, '0, '0, COUNT_W'(1), '0, '0, '0, COUNT_W'(1)));
        send_pair(pair_of('1, '1, '1, '1, '0, '0, '0, '1));
        send_pair(pair_of('0, '0, '0, MAX_REGION_PIXELS,
                          '1, '1, '1, MAX_REGION_PIXELS + COUNT_W'(1)));
        // An empty region costs nothing whatever the colors.
        send_pair(pair_of('1, '0, '1, '0, '0, '1, '0, COUNT_W'(500)));
        send_pair(pair_of('0, '1, '0, COUNT_W'(77), '1, '0, '1, '0));
        // Equal counts on both sides.
        send_pair(pair_of(16'h1234, 16'h8000, 16'h00FF, COUNT_W'(4096),
                          16'h4321, 16'h7FFF, 16'hFF00, COUNT_W'(4096)));
        send_pair(pair_of(16'd3, 16'd4, 16'd0, COUNT_W'(1000),
                          16'd0, 16'd0, 16'd0, COUNT_W'(9)));
        send_pair(pair_of(16'd1, 16'd1, 16'd1, COUNT_W'(2), '0, '0, '0, COUNT_W'(3)));
        // Identical means cost nothing even for the largest regions.
        send_pair(pair_of(16'hA5A5, 16'h5A5A, 16'hFFFF, '1,
                          16'hA5A5, 16'h5A5A, 16'hFFFF, '1));
        send_pair(pair_of(16'hFFFF, 16'h0000, 16'h0001, MAX_REGION_PIXELS - COUNT_W'(1),
                          16'h0000, 16'hFFFF, 16'hFFFE, MAX_REGION_PIXELS));
        send_pair(pair_of(16'd2, 16'd2, 16'd2, COUNT_W'(5), 16'd0, 16'd0, 16'd1, COUNT_W'(5)));

        // Directed pairs in the plain absolute difference mode.
        set_merge_mode(MODE_L1);
        send_pair(pair_of('1, '1, '1, '1, '0, '0, '0, '1));
        send_pair(pair_of('0, '0, '0, '0, '1, '1, '1, '0));
        send_pair(pair_of('0, '0, '0, '0, '0, '0, '0, '0));
        send_pair(pair_of(16'h0100, 16'hFF00, 16'h0080, COUNT_W'(1),
                          16'h0200, 16'h0F00, 16'h0080, MAX_REGION_PIXELS));
        send_pair(pair_of(16'h7FFF, 16'h8000, 16'h0001, COUNT_W'(12),
                          16'h8000, 16'h7FFF, 16'hFFFE, '0));

        // Random phases over both modes and all idle and stall patterns.
        run_phase(MODE_WEIGHTED, 0, 0);
        run_phase(MODE_L1, 0, 0);
        run_phase(MODE_WEIGHTED, 59, 0);
        run_phase(MODE_L1, 59, 0);
        run_phase(MODE_WEIGHTED, 0, 59);
        run_phase(MODE_L1, 0, 59);
        run_phase(MODE_WEIGHTED, 21, 21);
        run_phase(MODE_L1, 21, 21);

        // Let the pipeline empty out and watch for stray results afterwards.
        drain_results();
        stall_pct = 0;
        repeat (PIPE_SETTLE) @(posedge i_clk);

        $display("Sent %0d region pairs across %0d mode writes, four idle and stall patterns",
                 sent_count, mode_writes);
        $display("Checked %0d results, %0d mismatches, %0d still expected",
                 board.checked, board.mismatches, board.outstanding());
        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
